FILE: sv/mqtt_publish_deframer_defines.svh
// assertion macros for the mqtt publish deframer
// used by the modules that carry concurrent checks; no other dependencies
`ifndef MQTT_PUBLISH_DEFRAMER_DEFINES_SVH
`define MQTT_PUBLISH_DEFRAMER_DEFINES_SVH

// property checked on every rising clock edge outside of reset
`define MPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside of reset
`define MPD_NEVER(label, clk, rst_n, cond, msg) \
    `MPD_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: sv/mpd_pkg.sv
// shared types and constants for the mqtt publish deframer
// no dependencies
package mpd_pkg;

    localparam int LEN_W   = 28;
    localparam int TOPIC_W = 16;

    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_LENGTH  = 8'b0000_0010,
        PH_TLEN_HI = 8'b0000_0100,
        PH_TLEN_LO = 8'b0000_1000,
        PH_TOPIC   = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_SKIP    = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } t_phase;

    localparam logic [1:0] KIND_OTHER   = 2'd0;
    localparam logic [1:0] KIND_TOPIC   = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    typedef struct packed {
        t_phase             phase;
        logic [LEN_W-1:0]   bytes_left;
        logic [1:0]         varint_index;
        logic [TOPIC_W-1:0] topic_left;
        logic [7:0]         topic_high_byte;
        logic               publish_flag;
        logic               error_flag;
    } t_state;

    // handshake between the input register and the parser stage
    typedef struct packed {
        logic take;
    } t_link;

endpackage

FILE: sv/mpd_in_stage.sv
// input register of the deframer: holds one received byte for the parser
// depends on mpd_pkg
module mpd_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_byte,
    input  mpd_pkg::t_link i_link,
    output logic          o_valid,
    output logic [7:0]    o_byte
);
    import mpd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       load;

    assign load    = !r_valid || i_link.take;
    assign o_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

FILE: sv/mpd_parser.sv
// packet state, per-byte classification and result register of the deframer
// depends on mpd_pkg and mqtt_publish_deframer_defines.svh
`include "mqtt_publish_deframer_defines.svh"

module mpd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    output mpd_pkg::t_link o_link,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_data_byte,
    output logic [1:0]     o_byte_kind,
    output logic           o_packet_end,
    output logic           o_is_publish,
    output logic           o_stream_error
);
    import mpd_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic               take;
    logic               fire;
    logic [1:0]         kind;
    logic               pkt_end;
    logic               pub;
    logic               err_set;
    logic [LEN_W-1:0]   len_part;
    logic [LEN_W-1:0]   len_or;
    logic [LEN_W-1:0]   len_dec;
    logic [TOPIC_W-1:0] topic_len;
    logic [TOPIC_W-1:0] topic_dec;

    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic [1:0] r_out_kind;
    logic       r_out_end;
    logic       r_out_pub;
    logic       r_out_err;

    assign take        = !r_out_valid || !i_out_stall;
    assign fire        = i_valid && take;
    assign o_link.take = take;

    // 7-bit varint group placed at its little-endian position
    always_comb begin
        case (r_state.varint_index)
            2'd0:    len_part = {21'd0, i_byte[6:0]};
            2'd1:    len_part = {14'd0, i_byte[6:0], 7'd0};
            2'd2:    len_part = {7'd0, i_byte[6:0], 14'd0};
            default: len_part = {i_byte[6:0], 21'd0};
        endcase
    end

    assign len_or    = r_state.bytes_left | len_part;
    assign len_dec   = r_state.bytes_left - {{(LEN_W-1){1'b0}}, 1'b1};
    assign topic_len = {r_state.topic_high_byte, i_byte};
    assign topic_dec = r_state.topic_left - {{(TOPIC_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_state = r_state;
        kind    = KIND_OTHER;
        pkt_end = 1'b0;
        err_set = 1'b0;
        case (r_state.phase)
            PH_LENGTH: begin
                n_state.bytes_left = len_or;
                if (i_byte[7]) begin
                    if (r_state.varint_index == 2'd3) begin
                        err_set = 1'b1;
                    end else begin
                        n_state.varint_index = r_state.varint_index + 2'd1;
                    end
                end else if (r_state.publish_flag) begin
                    if (len_or < LEN_W'(2)) begin
                        err_set = 1'b1;
                    end else begin
                        n_state.phase = PH_TLEN_HI;
                    end
                end else if (len_or == '0) begin
                    pkt_end       = 1'b1;
                    n_state.phase = PH_HEADER;
                end else begin
                    n_state.phase = PH_SKIP;
                end
            end
            PH_TLEN_HI: begin
                n_state.topic_high_byte = i_byte;
                n_state.bytes_left      = len_dec;
                n_state.phase           = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
                n_state.topic_left = topic_len;
                n_state.bytes_left = len_dec;
                if ({{(LEN_W-TOPIC_W){1'b0}}, topic_len} > len_dec) begin
                    err_set = 1'b1;
                end else if (len_dec == '0) begin
                    pkt_end       = 1'b1;
                    n_state.phase = PH_HEADER;
                end else if (topic_len != '0) begin
                    n_state.phase = PH_TOPIC;
                end else begin
                    n_state.phase = PH_PAYLOAD;
                end
            end
            PH_TOPIC: begin
                kind               = KIND_TOPIC;
                n_state.topic_left = topic_dec;
                n_state.bytes_left = len_dec;
                if (len_dec == '0) begin
                    pkt_end       = 1'b1;
                    n_state.phase = PH_HEADER;
                end else if (topic_dec == '0) begin
                    n_state.phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD, PH_SKIP: begin
                if (r_state.phase == PH_PAYLOAD) begin
                    kind = KIND_PAYLOAD;
                end
                n_state.bytes_left = len_dec;
                if (len_dec == '0) begin
                    pkt_end       = 1'b1;
                    n_state.phase = PH_HEADER;
                end
            end
            PH_ERROR: begin
                n_state.phase = PH_ERROR;
            end
            default: begin
                // fixed header byte
                n_state.publish_flag    = (i_byte[7:4] == 4'h3);
                n_state.bytes_left      = '0;
                n_state.varint_index    = 2'd0;
                n_state.topic_left      = '0;
                n_state.topic_high_byte = 8'd0;
                n_state.phase           = PH_LENGTH;
            end
        endcase
        if (err_set) begin
            n_state.error_flag = 1'b1;
        end
        pub = n_state.publish_flag;
        // once in error every result is flagged and the parser stays put
        if (n_state.error_flag) begin
            n_state.phase = PH_ERROR;
            kind          = KIND_ERROR;
            pkt_end       = 1'b0;
            pub           = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_HEADER;
            r_state.bytes_left      <= '0;
            r_state.varint_index    <= 2'd0;
            r_state.topic_left      <= '0;
            r_state.topic_high_byte <= 8'd0;
            r_state.publish_flag    <= 1'b0;
            r_state.error_flag      <= 1'b0;
            r_out_valid             <= 1'b0;
        end else begin
            if (fire) begin
                r_state <= n_state;
            end
            if (take) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= i_byte;
            r_out_kind <= kind;
            r_out_end  <= pkt_end;
            r_out_pub  <= pub;
            r_out_err  <= n_state.error_flag;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_byte    = r_out_data;
    assign o_byte_kind    = r_out_kind;
    assign o_packet_end   = r_out_end;
    assign o_is_publish   = r_out_pub;
    assign o_stream_error = r_out_err;

    `MPD_ASSERT(a_err_sticky, i_clk, i_rst_n, r_state.error_flag |=> r_state.error_flag, "error flag cleared without reset")
    `MPD_ASSERT(a_err_phase, i_clk, i_rst_n, r_state.error_flag |-> (r_state.phase == PH_ERROR), "error flag set outside error phase")
    `MPD_NEVER(a_err_result, i_clk, i_rst_n, r_out_valid && r_out_err && ((r_out_kind != KIND_ERROR) || r_out_end || r_out_pub), "error result not fully flagged")
    `MPD_NEVER(a_topic_pub, i_clk, i_rst_n, r_out_valid && (r_out_kind == KIND_TOPIC) && !r_out_pub, "topic byte outside a publish")

endmodule

FILE: sv/mqtt_publish_deframer.sv
// MQTT publish deframer: one received broker byte in, one tagged byte out.
// Input channel: i_in_valid / o_in_stall with i_rx_byte; an item is taken at
// a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_data_byte, o_byte_kind
// (0 header, length field or skipped, 1 topic, 2 payload, 3 error), o_packet_end,
// o_is_publish and o_stream_error.
// Datapath: a taken byte sits in the input register and then passes to the
// result register, which drives the output.
// Throughput: one byte per cycle while the output is not stalled; the packet
// state (phase, remaining length and topic counters) is updated per byte.
// Reset (i_rst_n low, synchronous): both registers empty, parser waits for a
// fixed header byte, error flag cleared.
// Receiver stall: the result register holds its item; the input register keeps
// its byte, or takes one if it was empty, and o_in_stall is high while it is
// full until the result is taken.
// After a malformed length the error flag is sticky until reset; bytes are
// still passed through with kind 3.
// depends on mpd_pkg, mpd_in_stage and mpd_parser
module mqtt_publish_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_byte_kind,
    output logic       o_packet_end,
    output logic       o_is_publish,
    output logic       o_stream_error
);
    import mpd_pkg::*;

    t_link      link;
    logic       in_valid;
    logic [7:0] in_byte;

    mpd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_rx_byte),
        .i_link  (link),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    mpd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .i_byte         (in_byte),
        .o_link         (link),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_byte    (o_data_byte),
        .o_byte_kind    (o_byte_kind),
        .o_packet_end   (o_packet_end),
        .o_is_publish   (o_is_publish),
        .o_stream_error (o_stream_error)
    );

endmodule
